>>> rtl/core/acs_pkg.sv
package acs_pkg;

  localparam int BP_MAX      = 32;
  localparam int BP_COUNT_DEF = 16;

  localparam int COUNT_W  = 16;
  localparam int SEG_W    = $clog2(BP_MAX);
  localparam int DIFF_W   = 7;
  localparam int SLOPE_W  = 14;
  localparam int NUM_W    = SLOPE_W + DIFF_W;
  localparam int RECIP_W  = 16;
  localparam int PROD_W   = NUM_W + RECIP_W;
  localparam int MILLI_W  = 19;
  localparam int T0_W     = 12;
  localparam int TENTHS_W = 11;

  // reciprocal of 100 for the thousandths to tenths step
  localparam int R100_SHIFT = 24;
  localparam int R100_W     = 18;
  localparam int SCALE_W    = MILLI_W + R100_W;
  localparam logic [R100_W-1:0]  R100      = R100_W'((1 << R100_SHIFT) / 100);
  localparam logic [MILLI_W-1:0] HUNDRED   = MILLI_W'(100);

  localparam logic UNIT_KNOTS = 1'b0;
  localparam logic UNIT_MS    = 1'b1;

  localparam logic [SLOPE_W-1:0] TOP0_MS  = SLOPE_W'(3000);
  localparam logic [SLOPE_W-1:0] RISE1_MS = SLOPE_W'(2000);
  localparam logic [SLOPE_W-1:0] STEP_MS  = SLOPE_W'(5000);
  localparam logic [SLOPE_W-1:0] TOP0_KN  = SLOPE_W'(5835);
  localparam logic [SLOPE_W-1:0] RISE1_KN = SLOPE_W'(3890);
  localparam logic [SLOPE_W-1:0] STEP_KN  = SLOPE_W'(9725);

  localparam logic [TENTHS_W-1:0] LIM_MS = TENTHS_W'(600);
  localparam logic [TENTHS_W-1:0] LIM_KN = TENTHS_W'(1200);

  localparam logic [COUNT_W-1:0] BP_TABLE [BP_MAX] = '{
    16'd38,   16'd72,   16'd152,  16'd227,  16'd303,  16'd382,  16'd460,  16'd544,
    16'd627,  16'd706,  16'd785,  16'd864,  16'd944,  16'd1022, 16'd1101, 16'd1181,
    16'd1261, 16'd1341, 16'd1421, 16'd1501, 16'd1581, 16'd1661, 16'd1741, 16'd1821,
    16'd1901, 16'd1981, 16'd2061, 16'd2141, 16'd2221, 16'd2301, 16'd2381, 16'd2461
  };

  // floor(2^NUM_W / segment width), segment 0 spans zero to the first breakpoint
  localparam logic [RECIP_W-1:0] SEG_RECIP [BP_MAX] = '{
    16'd55188, 16'd61680, 16'd26214, 16'd27962, 16'd27594, 16'd26546, 16'd26886, 16'd24966,
    16'd25266, 16'd26546, 16'd26546, 16'd26546, 16'd26214, 16'd26886, 16'd26546, 16'd26214,
    16'd26214, 16'd26214, 16'd26214, 16'd26214, 16'd26214, 16'd26214, 16'd26214, 16'd26214,
    16'd26214, 16'd26214, 16'd26214, 16'd26214, 16'd26214, 16'd26214, 16'd26214, 16'd26214
  };

  typedef struct packed {
    logic               valid;
    logic               ms;
    logic               beyond;
    logic [SEG_W-1:0]   seg;
    logic [COUNT_W-1:0] count;
  } seg_word_t;

  typedef struct packed {
    logic               valid;
    logic               ms;
    logic               beyond;
    logic [MILLI_W-1:0] milli;
  } milli_word_t;

endpackage

>>> rtl/core/anemometer_count_to_speed_core.sv
// Converts an anemometer pulse count into wind speed in tenths of knots
// (unit_mode 0) or meters per second (unit_mode 1) along a 16-breakpoint
// piecewise linear curve, truncating each division, clamping to 1200 or 600
// with the saturated flag set. The datapath is an eight-stage pipeline: one
// word enters per clock when nothing is stalled. Each stage holds its own
// valid bit, so a stall on the result side backs up only through full
// stages and empty ones keep taking words. Write unit_mode only while no
// word is in flight.
module anemometer_count_to_speed_core #(
  parameter int BREAKPOINT_COUNT = acs_pkg::BP_COUNT_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          count_valid,
  output logic                          count_stall,
  input  logic [acs_pkg::COUNT_W-1:0]   raw_count,
  input  logic                          cfg_wr_en,
  input  logic                          cfg_wr_data,
  output logic                          speed_valid,
  input  logic                          speed_stall,
  output logic [acs_pkg::TENTHS_W-1:0]  speed_tenths,
  output logic                          saturated
);
  import acs_pkg::*;

  logic        unit_mode;
  logic        find_ready, interp_ready, scale_ready;
  seg_word_t   seg_word;
  milli_word_t milli_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      unit_mode <= UNIT_KNOTS;
    end else if (cfg_wr_en) begin
      unit_mode <= cfg_wr_data;
    end
  end

  assign count_stall = !find_ready;

  acs_seg_find #(
    .BREAKPOINT_COUNT(BREAKPOINT_COUNT)
  ) u_seg_find (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (count_valid),
    .in_count  (raw_count),
    .mode      (unit_mode),
    .in_ready  (find_ready),
    .out_word  (seg_word),
    .out_ready (interp_ready)
  );

  acs_interp u_interp (
    .clk       (clk),
    .rst       (rst),
    .in_word   (seg_word),
    .in_ready  (interp_ready),
    .out_word  (milli_word),
    .out_ready (scale_ready)
  );

  acs_scale u_scale (
    .clk        (clk),
    .rst        (rst),
    .in_word    (milli_word),
    .in_ready   (scale_ready),
    .out_valid  (speed_valid),
    .out_tenths (speed_tenths),
    .out_sat    (saturated),
    .out_ready  (!speed_stall)
  );

endmodule

>>> rtl/core/acs_seg_find.sv
module acs_seg_find #(
  parameter int BREAKPOINT_COUNT = acs_pkg::BP_COUNT_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic [acs_pkg::COUNT_W-1:0]  in_count,
  input  logic                         mode,
  output logic                         in_ready,
  output acs_pkg::seg_word_t           out_word,
  input  logic                         out_ready
);
  import acs_pkg::*;

  localparam int NB = (BREAKPOINT_COUNT > BP_MAX) ? BP_MAX :
                      ((BREAKPOINT_COUNT < 3) ? 3 : BREAKPOINT_COUNT);

  logic               en;
  logic [SEG_W-1:0]   seg_c;
  logic               beyond_c;
  seg_word_t          word;

  assign en       = !word.valid || out_ready;
  assign in_ready = en;
  assign out_word = word;

  // breakpoints rise, so the lowest one above the count names the segment
  always_comb begin
    seg_c = SEG_W'(NB - 1);
    for (int i = NB - 1; i >= 2; i--) begin
      if (in_count < BP_TABLE[i]) seg_c = SEG_W'(i);
    end
    if (in_count <= BP_TABLE[0]) begin
      seg_c = '0;
    end else if (in_count <= BP_TABLE[1]) begin
      seg_c = SEG_W'(1);
    end
    beyond_c = (in_count > BP_TABLE[1]) && (in_count >= BP_TABLE[NB-1]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word.valid <= 1'b0;
    end else if (en) begin
      word.valid <= in_valid;
    end
    if (en) begin
      word.ms     <= (mode == UNIT_MS);
      word.beyond <= beyond_c;
      word.seg    <= seg_c;
      word.count  <= in_count;
    end
  end

endmodule

>>> rtl/core/acs_interp.sv
module acs_interp (
  input  logic                clk,
  input  logic                rst,
  input  acs_pkg::seg_word_t  in_word,
  output logic                in_ready,
  output acs_pkg::milli_word_t out_word,
  input  logic                out_ready
);
  import acs_pkg::*;

  logic en_a, en_b, en_c, en_d;
  logic v_a, v_b, v_c, v_d;

  // stage A: slope times offset into the segment
  logic [SLOPE_W-1:0] slope_c, top0_c, rise1_c, step_c;
  logic [COUNT_W-1:0] lo_c;
  logic [DIFF_W-1:0]  x_c, width_c;
  logic [MILLI_W-1:0] base_c;
  logic [NUM_W-1:0]   num_a;
  logic [MILLI_W-1:0] base_a;
  logic [RECIP_W-1:0] recip_a;
  logic [DIFF_W-1:0]  width_a;
  logic               ms_a, beyond_a;

  // stage B: quotient estimate through the reciprocal
  logic [PROD_W-1:0]  prod_c;
  logic [SLOPE_W-1:0] q0_b;
  logic [NUM_W-1:0]   num_b;
  logic [MILLI_W-1:0] base_b;
  logic [DIFF_W-1:0]  width_b;
  logic               ms_b, beyond_b;

  // stage C: remainder check, estimate is at most one low
  logic [NUM_W-1:0]   rem_c;
  logic               fix_c;
  logic [SLOPE_W-1:0] q0_c;
  logic [MILLI_W-1:0] base_cr;
  logic               ms_c, beyond_c;

  // stage D: thousandths
  logic [MILLI_W-1:0] milli_d;
  logic               ms_d, beyond_d;

  assign en_d     = !v_d || out_ready;
  assign en_c     = !v_c || en_d;
  assign en_b     = !v_b || en_c;
  assign en_a     = !v_a || en_b;
  assign in_ready = en_a;

  always_comb begin
    top0_c  = in_word.ms ? TOP0_MS  : TOP0_KN;
    rise1_c = in_word.ms ? RISE1_MS : RISE1_KN;
    step_c  = in_word.ms ? STEP_MS  : STEP_KN;
    lo_c    = (in_word.seg == '0) ? '0 : BP_TABLE[in_word.seg - SEG_W'(1)];
    x_c     = DIFF_W'(in_word.count - lo_c);
    width_c = DIFF_W'(BP_TABLE[in_word.seg] - lo_c);
    case (in_word.seg)
      SEG_W'(0): begin
        slope_c = top0_c;
        base_c  = '0;
      end
      SEG_W'(1): begin
        slope_c = rise1_c;
        base_c  = MILLI_W'(top0_c);
      end
      default: begin
        slope_c = step_c;
        base_c  = MILLI_W'(step_c) * MILLI_W'(in_word.seg - SEG_W'(1));
      end
    endcase
  end

  assign prod_c = PROD_W'(num_a) * PROD_W'(recip_a);
  assign rem_c  = num_b - NUM_W'(q0_b) * NUM_W'(width_b);

  always_ff @(posedge clk) begin
    if (rst) begin
      v_a <= 1'b0;
      v_b <= 1'b0;
      v_c <= 1'b0;
      v_d <= 1'b0;
    end else begin
      if (en_a) v_a <= in_word.valid;
      if (en_b) v_b <= v_a;
      if (en_c) v_c <= v_b;
      if (en_d) v_d <= v_c;
    end
  end

  always_ff @(posedge clk) begin
    if (en_a) begin
      num_a    <= NUM_W'(slope_c) * NUM_W'(x_c);
      base_a   <= base_c;
      recip_a  <= SEG_RECIP[in_word.seg];
      width_a  <= width_c;
      ms_a     <= in_word.ms;
      beyond_a <= in_word.beyond;
    end
    if (en_b) begin
      q0_b     <= prod_c[NUM_W +: SLOPE_W];
      num_b    <= num_a;
      base_b   <= base_a;
      width_b  <= width_a;
      ms_b     <= ms_a;
      beyond_b <= beyond_a;
    end
    if (en_c) begin
      fix_c    <= (rem_c >= NUM_W'(width_b));
      q0_c     <= q0_b;
      base_cr  <= base_b;
      ms_c     <= ms_b;
      beyond_c <= beyond_b;
    end
    if (en_d) begin
      milli_d  <= base_cr + MILLI_W'(q0_c) + MILLI_W'(fix_c);
      ms_d     <= ms_c;
      beyond_d <= beyond_c;
    end
  end

  assign out_word.valid  = v_d;
  assign out_word.ms     = ms_d;
  assign out_word.beyond = beyond_d;
  assign out_word.milli  = milli_d;

endmodule

>>> rtl/core/acs_scale.sv
module acs_scale (
  input  logic                          clk,
  input  logic                          rst,
  input  acs_pkg::milli_word_t          in_word,
  output logic                          in_ready,
  output logic                          out_valid,
  output logic [acs_pkg::TENTHS_W-1:0]  out_tenths,
  output logic                          out_sat,
  input  logic                          out_ready
);
  import acs_pkg::*;

  logic en_e, en_f, en_g;
  logic v_e, v_f, v_g;

  logic [SCALE_W-1:0] scale_c;
  logic [T0_W-1:0]    t0_e;
  logic [MILLI_W-1:0] milli_e;
  logic               ms_e, beyond_e;

  logic [MILLI_W-1:0] rem_c;
  logic [T0_W-1:0]    t_f;
  logic               ms_f, beyond_f;

  logic [TENTHS_W-1:0] lim_c;
  logic                sat_c;
  logic [TENTHS_W-1:0] tenths_g;
  logic                sat_g;

  assign en_g     = !v_g || out_ready;
  assign en_f     = !v_f || en_g;
  assign en_e     = !v_e || en_f;
  assign in_ready = en_e;

  assign scale_c = SCALE_W'(in_word.milli) * SCALE_W'(R100);
  assign rem_c   = milli_e - MILLI_W'(t0_e) * HUNDRED;

  assign lim_c = ms_f ? LIM_MS : LIM_KN;
  assign sat_c = beyond_f || (t_f >= T0_W'(lim_c));

  always_ff @(posedge clk) begin
    if (rst) begin
      v_e <= 1'b0;
      v_f <= 1'b0;
      v_g <= 1'b0;
    end else begin
      if (en_e) v_e <= in_word.valid;
      if (en_f) v_f <= v_e;
      if (en_g) v_g <= v_f;
    end
  end

  always_ff @(posedge clk) begin
    if (en_e) begin
      t0_e     <= scale_c[R100_SHIFT +: T0_W];
      milli_e  <= in_word.milli;
      ms_e     <= in_word.ms;
      beyond_e <= in_word.beyond;
    end
    if (en_f) begin
      // estimate is at most one low
      t_f      <= t0_e + T0_W'(rem_c >= HUNDRED);
      ms_f     <= ms_e;
      beyond_f <= beyond_e;
    end
    if (en_g) begin
      tenths_g <= sat_c ? lim_c : TENTHS_W'(t_f);
      sat_g    <= sat_c;
    end
  end

  assign out_valid  = v_g;
  assign out_tenths = tenths_g;
  assign out_sat    = sat_g;

endmodule

>>> rtl/core/acs_checker.sv
module acs_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          cfg_wr_en,
  input logic                          cfg_wr_data,
  input logic                          speed_valid,
  input logic                          speed_stall,
  input logic [acs_pkg::TENTHS_W-1:0]  speed_tenths,
  input logic                          saturated
);
  import acs_pkg::*;

  logic mode_ms;

  // shadow of the unit register as seen on the port
  always_ff @(posedge clk) begin
    if (rst) begin
      mode_ms <= 1'b0;
    end else if (cfg_wr_en) begin
      mode_ms <= (cfg_wr_data == UNIT_MS);
    end
  end

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    speed_valid && speed_stall |=> speed_valid && $stable(speed_tenths) && $stable(saturated))
    else $error("stalled speed word changed");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !speed_valid)
    else $error("speed word valid right after reset");

  a_limit_ms: assert property (@(posedge clk) disable iff (rst)
    speed_valid && mode_ms |->
      (saturated == (speed_tenths == LIM_MS)) && (speed_tenths <= LIM_MS))
    else $error("m/s result outside limit or flag mismatch");

  a_limit_kn: assert property (@(posedge clk) disable iff (rst)
    speed_valid && !mode_ms |->
      (saturated == (speed_tenths == LIM_KN)) && (speed_tenths <= LIM_KN))
    else $error("knots result outside limit or flag mismatch");

endmodule

bind anemometer_count_to_speed_core acs_checker u_acs_checker (.*);

>>> verif/speed_checker.sv
`timescale 1ns / 100ps

module speed_checker #(
  parameter int BREAKPOINT_COUNT = acs_pkg::BP_COUNT_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          count_valid,
  input  logic                          count_stall,
  input  logic [acs_pkg::COUNT_W-1:0]   raw_count,
  input  logic                          cfg_wr_en,
  input  logic                          cfg_wr_data,
  input  logic                          speed_valid,
  input  logic                          speed_stall,
  input  logic [acs_pkg::TENTHS_W-1:0]  speed_tenths,
  input  logic                          saturated,
  output int                            words_in_flight,
  output int                            fail_count
);

  localparam int NUM_BP = (BREAKPOINT_COUNT > acs_pkg::BP_MAX) ? acs_pkg::BP_MAX :
                          (BREAKPOINT_COUNT < 3) ? 3 : BREAKPOINT_COUNT;

  typedef struct packed {
    logic [acs_pkg::TENTHS_W-1:0] tenths;
    logic                         sat;
  } speed_t;

  speed_t expected_speeds[$];
  logic   unit_mode;

  function automatic speed_t predict_speed(logic [acs_pkg::COUNT_W-1:0] cnt, logic unit);
    int unsigned top0, rise1, step, lim, milli, tenths, lo, hi, c;
    bit          sat, found;
    speed_t      res;
    c     = cnt;
    top0  = (unit == acs_pkg::UNIT_MS) ? acs_pkg::TOP0_MS  : acs_pkg::TOP0_KN;
    rise1 = (unit == acs_pkg::UNIT_MS) ? acs_pkg::RISE1_MS : acs_pkg::RISE1_KN;
    step  = (unit == acs_pkg::UNIT_MS) ? acs_pkg::STEP_MS  : acs_pkg::STEP_KN;
    lim   = (unit == acs_pkg::UNIT_MS) ? acs_pkg::LIM_MS   : acs_pkg::LIM_KN;
    milli = 0;
    sat   = 0;
    found = 0;
    if (c == 0) begin
      milli = 0;
    end else if (c <= acs_pkg::BP_TABLE[0]) begin
      milli = top0 * c / acs_pkg::BP_TABLE[0];
    end else if (c <= acs_pkg::BP_TABLE[1]) begin
      lo    = acs_pkg::BP_TABLE[0];
      hi    = acs_pkg::BP_TABLE[1];
      milli = top0 + rise1 * (c - lo) / (hi - lo);
    end else begin
      for (int i = 2; i < NUM_BP; i++) begin
        if (!found && c < acs_pkg::BP_TABLE[i]) begin
          lo    = acs_pkg::BP_TABLE[i-1];
          hi    = acs_pkg::BP_TABLE[i];
          milli = step * (i - 1) + step * (c - lo) / (hi - lo);
          found = 1;
        end
      end
      // past the last breakpoint: clamp
      if (!found) sat = 1;
    end
    if (sat) begin
      tenths = lim;
    end else begin
      tenths = milli / 100;
      if (tenths > lim - 1) begin
        tenths = lim;
        sat    = 1;
      end
    end
    res.tenths = tenths[acs_pkg::TENTHS_W-1:0];
    res.sat    = sat;
    return res;
  endfunction

  initial begin
    unit_mode       = acs_pkg::UNIT_KNOTS;
    words_in_flight = 0;
    fail_count      = 0;
  end

  always @(posedge clk) begin
    speed_t exp_word;
    if (rst) begin
      unit_mode = acs_pkg::UNIT_KNOTS;
      expected_speeds.delete();
    end else begin
      // check the outgoing word before queueing the incoming one
      if (speed_valid && !speed_stall) begin
        if (expected_speeds.size() == 0) begin
          $error("speed word with nothing expected: speed_tenths %0d, saturated %0d",
                 speed_tenths, saturated);
          fail_count++;
        end else begin
          exp_word = expected_speeds.pop_front();
          if (speed_tenths !== exp_word.tenths) begin
            $error("speed_tenths: expected %0d, got %0d", exp_word.tenths, speed_tenths);
            fail_count++;
          end
          if (saturated !== exp_word.sat) begin
            $error("saturated: expected %0d, got %0d", exp_word.sat, saturated);
            fail_count++;
          end
        end
      end
      if (count_valid && !count_stall)
        expected_speeds.push_back(predict_speed(raw_count, unit_mode));
      if (cfg_wr_en)
        unit_mode = cfg_wr_data;
    end
    words_in_flight = expected_speeds.size();
  end

endmodule

>>> verif/tb.sv
`timescale 1ns / 100ps

module tb;

  localparam int WORDS_PER_PHASE = 465;
  localparam int DRAIN_CYCLES    = 20;
  localparam int CNT_W           = acs_pkg::COUNT_W;

  logic                          clk          = 1'b0;
  logic                          rst          = 1'b1;
  logic                          count_valid  = 1'b0;
  logic                          count_stall;
  logic [acs_pkg::COUNT_W-1:0]   raw_count    = '0;
  logic                          cfg_wr_en    = 1'b0;
  logic                          cfg_wr_data  = 1'b0;
  logic                          speed_valid;
  logic                          speed_stall  = 1'b0;
  logic [acs_pkg::TENTHS_W-1:0]  speed_tenths;
  logic                          saturated;

  int words_in_flight;
  int fail_count;
  int idle_pct  = 0;
  int stall_pct = 0;

  int edge_counts[] = '{0, 1, 37, 38, 39, 71, 72, 73, 151, 152, 153, 226, 227, 943, 944,
                        1100, 1180, 1181, 1182, 16'h5555, 16'hAAAA, 16'hFFFF, 600};

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  anemometer_count_to_speed_core DUT (
    .clk          (clk),
    .rst          (rst),
    .count_valid  (count_valid),
    .count_stall  (count_stall),
    .raw_count    (raw_count),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .speed_valid  (speed_valid),
    .speed_stall  (speed_stall),
    .speed_tenths (speed_tenths),
    .saturated    (saturated)
  );

  speed_checker checker_i (
    .clk             (clk),
    .rst             (rst),
    .count_valid     (count_valid),
    .count_stall     (count_stall),
    .raw_count       (raw_count),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .speed_valid     (speed_valid),
    .speed_stall     (speed_stall),
    .speed_tenths    (speed_tenths),
    .saturated       (saturated),
    .words_in_flight (words_in_flight),
    .fail_count      (fail_count)
  );

  always @(posedge clk) begin
    if (rst)
      speed_stall <= 1'b0;
    else
      speed_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  // drive one count word and hold it until the core takes it
  task automatic send_count(input logic [acs_pkg::COUNT_W-1:0] cnt);
    while ($urandom_range(0, 99) < idle_pct) begin
      count_valid <= 1'b0;
      @(posedge clk);
    end
    count_valid <= 1'b1;
    raw_count   <= cnt;
    do @(posedge clk); while (count_stall);
  endtask

  // drain the pipeline, then write the unit register
  task automatic set_unit(input logic unit);
    count_valid <= 1'b0;
    @(posedge clk);
    while (words_in_flight != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= unit;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  function automatic logic [acs_pkg::COUNT_W-1:0] pick_count();
    int sel;
    int bp;
    sel = $urandom_range(0, 99);
    if (sel < 65)
      return CNT_W'($urandom_range(0, 1250));
    if (sel < 80) begin
      bp = acs_pkg::BP_TABLE[$urandom_range(0, 15)];
      return CNT_W'(bp + $urandom_range(0, 4) - 2);
    end
    return CNT_W'($urandom());
  endfunction

  task automatic run_phase(input logic unit, input int sender_idle, input int recv_stall);
    set_unit(unit);
    idle_pct  = sender_idle;
    stall_pct = recv_stall;
    for (int k = 0; k < WORDS_PER_PHASE; k++) begin
      // break the phase into runs with and without gaps
      if (k % 150 == 100) begin
        idle_pct  = 0;
        stall_pct = 0;
      end else if (k % 150 == 0) begin
        idle_pct  = sender_idle;
        stall_pct = recv_stall;
      end
      send_count(pick_count());
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    set_unit(acs_pkg::UNIT_KNOTS);
    foreach (edge_counts[i]) send_count(CNT_W'(edge_counts[i]));
    set_unit(acs_pkg::UNIT_MS);
    foreach (edge_counts[i]) send_count(CNT_W'(edge_counts[i]));

    run_phase(acs_pkg::UNIT_KNOTS, 0, 0);
    run_phase(acs_pkg::UNIT_MS, 83, 0);
    run_phase(acs_pkg::UNIT_KNOTS, 0, 83);
    run_phase(acs_pkg::UNIT_MS, 8, 8);

    count_valid <= 1'b0;
    @(posedge clk);
    while (words_in_flight != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #5ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
